@@ sv/tvf_pkg.sv @@
// Shared types and constants for the triangle viscous flux block.
// Holds the queued corner record, multiplier op codes and saturation helper.
// No dependencies.
`timescale 1ns / 1ps

package tvf_pkg;

    // Operand width of the shared multiplier and width of the accumulators
    localparam int OPW      = 48;
    localparam int ACC_BITS = 48;
    // Signed rounded product, magnitude clamped to 2^60
    localparam int PRODW    = 62;

    // Corner codes
    localparam logic [1:0] CORNER_FIRST = 2'd0;
    localparam logic [1:0] CORNER_LAST  = 2'd2;
    localparam logic [1:0] CORNER_NONE  = 2'd3;

    // Multiplier operations, issued in this order; the code is the step number
    typedef enum logic [4:0] {
        OP_GXU  = 5'd0,
        OP_GYU  = 5'd1,
        OP_GXV  = 5'd2,
        OP_GYV  = 5'd3,
        OP_GXT  = 5'd4,
        OP_GYT  = 5'd5,
        OP_UMU  = 5'd6,
        OP_VMU  = 5'd7,
        OP_UX   = 5'd8,
        OP_UY   = 5'd9,
        OP_VX   = 5'd10,
        OP_VY   = 5'd11,
        OP_TX   = 5'd12,
        OP_TY   = 5'd13,
        OP_MUA  = 5'd14,
        OP_KPA  = 5'd15,
        OP_UMUA = 5'd16,
        OP_VMUA = 5'd17,
        OP_DD   = 5'd18,
        OP_SXX  = 5'd19,
        OP_SXY  = 5'd20,
        OP_SYY  = 5'd21,
        OP_EXA  = 5'd22,
        OP_EXB  = 5'd23,
        OP_EXC  = 5'd24,
        OP_EYA  = 5'd25,
        OP_EYB  = 5'd26,
        OP_EYC  = 5'd27
    } op_t;

    // One queued corner
    typedef struct packed {
        logic               clear;
        logic               emit;
        logic signed [31:0] vel_u;
        logic signed [31:0] vel_v;
        logic signed [31:0] temperature;
        logic        [30:0] viscosity;
        logic        [30:0] conductivity;
        logic signed [31:0] grad_x;
        logic signed [31:0] grad_y;
        logic signed [31:0] cell_scale;
    } item_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } mul_req_t;

    typedef struct packed {
        logic                    valid;
        op_t                     op;
        logic signed [PRODW-1:0] res;
    } mul_rsp_t;

    // Saturate to a signed width of the given number of bits
    function automatic logic signed [63:0] sat_to(input logic signed [63:0] x,
                                                  input int bits);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (x > hi)
            return hi;
        else if (x < lo)
            return lo;
        else
            return x;
    endfunction

endpackage

@@ sv/tvf_front.sv @@
// Front end: command handshake, corner classification and a two-entry queue.
// Depends on tvf_pkg.
`timescale 1ns / 1ps

module tvf_front
    import tvf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         corner,
    input  logic signed [31:0] vel_u,
    input  logic signed [31:0] vel_v,
    input  logic signed [31:0] temperature,
    input  logic        [30:0] viscosity,
    input  logic        [30:0] conductivity,
    input  logic signed [31:0] grad_x,
    input  logic signed [31:0] grad_y,
    input  logic signed [31:0] cell_scale,
    input  logic               pop,
    output logic               head_valid,
    output item_t              head
);

    item_t      q_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    item_t      item_in;

    // Corner three is taken and dropped
    assign busy = (cnt_reg == 2'd2);
    assign push = start && !busy && (corner != CORNER_NONE);

    always_comb
    begin
        item_in.clear        = (corner == CORNER_FIRST);
        item_in.emit         = (corner == CORNER_LAST);
        item_in.vel_u        = vel_u;
        item_in.vel_v        = vel_v;
        item_in.temperature  = temperature;
        item_in.viscosity    = viscosity;
        item_in.conductivity = conductivity;
        item_in.grad_x       = grad_x;
        item_in.grad_y       = grad_y;
        item_in.cell_scale   = cell_scale;
    end

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= item_in;
    end

    assign head_valid = (cnt_reg != 2'd0);
    assign head       = q_mem[rd_ptr_reg];

    // The back end never takes from an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty corner queue");

endmodule

@@ sv/tvf_mul.sv @@
// Shared three-stage fixed-point multiplier: sign/magnitude, four partial
// products, then sum, round to nearest (ties away) and clamp. Depends on tvf_pkg.
`timescale 1ns / 1ps

module tvf_mul
    import tvf_pkg::*;
#(
    parameter int FRAC_BITS = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mul_req_t              req,
    input  logic signed [OPW-1:0] op_a,
    input  logic signed [OPW-1:0] op_b,
    output mul_rsp_t              rsp,
    output logic                  pending
);

    localparam int HW = OPW / 2;
    localparam int PW = 2 * OPW;

    logic               s1_valid_reg, s2_valid_reg;
    op_t                s1_op_reg, s2_op_reg;
    logic               s1_neg_reg, s2_neg_reg;
    logic [OPW-1:0]     mag_a_reg, mag_b_reg;
    logic [OPW-1:0]     pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic               rsp_valid_reg;
    op_t                rsp_op_reg;
    logic signed [PRODW-1:0] rsp_res_reg;

    logic [OPW-1:0]     mag_a, mag_b;
    logic [PW-1:0]      prod, rnd, mq, mclamp;
    logic [PRODW-1:0]   mag_p;
    logic signed [PRODW-1:0] res_next;

    localparam logic [PW-1:0] CAP  = PW'(1) << 60;
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

    // Stage 1 operands
    assign mag_a = op_a[OPW-1] ? OPW'(-op_a) : OPW'(op_a);
    assign mag_b = op_b[OPW-1] ? OPW'(-op_b) : OPW'(op_b);

    // Stage 3 combine, round and clamp
    always_comb
    begin
        prod   = {pp_hh_reg, {OPW{1'b0}}}
               + ({{OPW{1'b0}}, pp_lh_reg} << HW)
               + ({{OPW{1'b0}}, pp_hl_reg} << HW)
               + {{OPW{1'b0}}, pp_ll_reg};
        rnd    = prod + HALF;
        mq     = rnd >> FRAC_BITS;
        mclamp = (mq > CAP) ? CAP : mq;
        mag_p  = mclamp[PRODW-1:0];
        res_next = s2_neg_reg ? -$signed(mag_p) : $signed(mag_p);
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= req.valid;
            s2_valid_reg  <= s1_valid_reg;
            rsp_valid_reg <= s2_valid_reg;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        s1_op_reg   <= req.op;
        s1_neg_reg  <= op_a[OPW-1] ^ op_b[OPW-1];
        mag_a_reg   <= mag_a;
        mag_b_reg   <= mag_b;
        s2_op_reg   <= s1_op_reg;
        s2_neg_reg  <= s1_neg_reg;
        pp_ll_reg   <= mag_a_reg[HW-1:0]   * mag_b_reg[HW-1:0];
        pp_lh_reg   <= mag_a_reg[HW-1:0]   * mag_b_reg[OPW-1:HW];
        pp_hl_reg   <= mag_a_reg[OPW-1:HW] * mag_b_reg[HW-1:0];
        pp_hh_reg   <= mag_a_reg[OPW-1:HW] * mag_b_reg[OPW-1:HW];
        rsp_op_reg  <= s2_op_reg;
        rsp_res_reg <= res_next;
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.op    = rsp_op_reg;
    assign rsp.res   = rsp_res_reg;
    assign pending   = s1_valid_reg || s2_valid_reg || rsp_valid_reg;

    // Each result follows its request through the s1, s2 and response registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> $past(req.valid, 3))
        else $error("multiplier result without matching request");

endmodule

@@ sv/tvf_back.sv @@
// Back end: sequencer that drives the shared multiplier, the gradient and
// corner sums, the flux terms and the result registers. Depends on tvf_pkg.
`timescale 1ns / 1ps

module tvf_back
    import tvf_pkg::*;
#(
    parameter int FRAC_BITS = 20,
    parameter int WORD_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  item_t                 head,
    output logic                  pop,
    output mul_req_t              req,
    output logic signed [OPW-1:0] op_a,
    output logic signed [OPW-1:0] op_b,
    input  mul_rsp_t              rsp,
    input  logic                  pending,
    output logic                  done,
    output logic signed [31:0]    stress_xx,
    output logic signed [31:0]    stress_xy,
    output logic signed [31:0]    energy_x,
    output logic signed [31:0]    stress_yy,
    output logic signed [31:0]    energy_y
);

    localparam logic signed [OPW-1:0] THIRD = OPW'(((64'd1 << FRAC_BITS) + 64'd1) / 64'd3);
    localparam logic [4:0] N_ACC_OPS = 5'd8;
    localparam logic [4:0] N_ALL_OPS = 5'd28;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [4:0] step_reg, step_next;
    item_t item_reg;

    logic signed [ACC_BITS-1:0] gs_reg [6];
    logic signed [ACC_BITS-1:0] as_reg [6];
    logic signed [OPW-1:0] ux_reg, uy_reg, vx_reg, vy_reg, tx_reg, ty_reg;
    logic signed [OPW-1:0] mua_reg, kpa_reg, umua_reg, vmua_reg, dd_reg;
    logic signed [63:0]    ex_acc_reg, ey_acc_reg;
    logic signed [31:0]    sxx_reg, sxy_reg, syy_reg, ex_out_reg, ey_out_reg;
    logic                  done_reg;

    logic       load, issue, barrier;
    logic [4:0] last_step;
    op_t        issue_op;
    logic signed [63:0] term, wb_neg_sat, wb_sat, wb_dbl_sat;
    logic signed [63:0] uv_sat, exx_sat, eyy_sat, sh_sat, ex_sat, ey_sat;
    logic signed [63:0] as_in [4];
    logic signed [OPW-1:0] exx, eyy, sh;

    // Sequencer control
    assign last_step = item_reg.emit ? N_ALL_OPS : N_ACC_OPS;
    assign barrier   = (step_reg == 5'(OP_UX)) || (step_reg == 5'(OP_DD))
                    || (step_reg == 5'(OP_SXX));
    assign load      = (state_reg == S_IDLE) && head_valid;
    assign issue     = (state_reg == S_RUN) && (step_reg != last_step)
                    && !(barrier && pending);
    assign issue_op  = op_t'(step_reg);
    assign pop       = load;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    state_next = S_RUN;
                    step_next  = 5'd0;
                end
            end
            S_RUN:
            begin
                if (issue)
                    step_next = step_reg + 5'd1;
                else if ((step_reg == last_step) && !pending)
                    state_next = item_reg.emit ? S_OUT : S_IDLE;
            end
            S_OUT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= 5'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= (state_reg == S_OUT);
        end
    end

    // Derived terms for the flux products
    always_comb
    begin
        uv_sat  = sat_to(64'(ux_reg) + 64'(vy_reg), WORD_BITS);
        exx_sat = sat_to(64'(ux_reg) - 64'(dd_reg), WORD_BITS);
        eyy_sat = sat_to(64'(vy_reg) - 64'(dd_reg), WORD_BITS);
        sh_sat  = sat_to(64'(uy_reg) + 64'(vx_reg), WORD_BITS);
        exx     = exx_sat[OPW-1:0];
        eyy     = eyy_sat[OPW-1:0];
        sh      = sh_sat[OPW-1:0];
    end

    // Operand select
    always_comb
    begin
        req.valid = issue;
        req.op    = issue_op;
        op_a      = '0;
        op_b      = '0;
        case (issue_op)
            OP_GXU:  begin op_a = OPW'(item_reg.grad_x); op_b = OPW'(item_reg.vel_u); end
            OP_GYU:  begin op_a = OPW'(item_reg.grad_y); op_b = OPW'(item_reg.vel_u); end
            OP_GXV:  begin op_a = OPW'(item_reg.grad_x); op_b = OPW'(item_reg.vel_v); end
            OP_GYV:  begin op_a = OPW'(item_reg.grad_y); op_b = OPW'(item_reg.vel_v); end
            OP_GXT:  begin op_a = OPW'(item_reg.grad_x); op_b = OPW'(item_reg.temperature); end
            OP_GYT:  begin op_a = OPW'(item_reg.grad_y); op_b = OPW'(item_reg.temperature); end
            OP_UMU:
            begin
                op_a = OPW'(item_reg.vel_u);
                op_b = $signed({{(OPW-31){1'b0}}, item_reg.viscosity});
            end
            OP_VMU:
            begin
                op_a = OPW'(item_reg.vel_v);
                op_b = $signed({{(OPW-31){1'b0}}, item_reg.viscosity});
            end
            OP_UX:   begin op_a = gs_reg[0]; op_b = OPW'(item_reg.cell_scale); end
            OP_UY:   begin op_a = gs_reg[1]; op_b = OPW'(item_reg.cell_scale); end
            OP_VX:   begin op_a = gs_reg[2]; op_b = OPW'(item_reg.cell_scale); end
            OP_VY:   begin op_a = gs_reg[3]; op_b = OPW'(item_reg.cell_scale); end
            OP_TX:   begin op_a = gs_reg[4]; op_b = OPW'(item_reg.cell_scale); end
            OP_TY:   begin op_a = gs_reg[5]; op_b = OPW'(item_reg.cell_scale); end
            OP_MUA:  begin op_a = as_reg[2]; op_b = THIRD; end
            OP_KPA:  begin op_a = as_reg[3]; op_b = THIRD; end
            OP_UMUA: begin op_a = as_reg[4]; op_b = THIRD; end
            OP_VMUA: begin op_a = as_reg[5]; op_b = THIRD; end
            OP_DD:   begin op_a = uv_sat[OPW-1:0]; op_b = THIRD; end
            OP_SXX:  begin op_a = mua_reg;  op_b = exx; end
            OP_SXY:  begin op_a = mua_reg;  op_b = sh; end
            OP_SYY:  begin op_a = mua_reg;  op_b = eyy; end
            OP_EXA:  begin op_a = umua_reg; op_b = exx; end
            OP_EXB:  begin op_a = vmua_reg; op_b = sh; end
            OP_EXC:  begin op_a = kpa_reg;  op_b = tx_reg; end
            OP_EYA:  begin op_a = vmua_reg; op_b = eyy; end
            OP_EYB:  begin op_a = umua_reg; op_b = sh; end
            OP_EYC:  begin op_a = kpa_reg;  op_b = ty_reg; end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    // Writeback values
    always_comb
    begin
        term       = 64'(rsp.res);
        wb_neg_sat = sat_to(-term, WORD_BITS);
        wb_sat     = sat_to(term, WORD_BITS);
        wb_dbl_sat = sat_to(term <<< 1, WORD_BITS);
        ex_sat     = sat_to(ex_acc_reg, WORD_BITS);
        ey_sat     = sat_to(ey_acc_reg, WORD_BITS);
        as_in[0]   = sat_to((head.clear ? 64'sd0 : 64'(as_reg[0])) + 64'(head.vel_u),
                            ACC_BITS);
        as_in[1]   = sat_to((head.clear ? 64'sd0 : 64'(as_reg[1])) + 64'(head.vel_v),
                            ACC_BITS);
        as_in[2]   = sat_to((head.clear ? 64'sd0 : 64'(as_reg[2]))
                            + $signed({33'd0, head.viscosity}), ACC_BITS);
        as_in[3]   = sat_to((head.clear ? 64'sd0 : 64'(as_reg[3]))
                            + $signed({33'd0, head.conductivity}), ACC_BITS);
    end

    // Cell sums: cleared by corner zero, direct terms on load, products on return
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                gs_reg[i] <= '0;
                as_reg[i] <= '0;
            end
        end
        else if (load)
        begin
            for (int i = 0; i < 4; i++)
                as_reg[i] <= as_in[i][ACC_BITS-1:0];
            if (head.clear)
            begin
                for (int i = 0; i < 6; i++)
                    gs_reg[i] <= '0;
                as_reg[4] <= '0;
                as_reg[5] <= '0;
            end
        end
        else if (rsp.valid)
        begin
            case (rsp.op)
                OP_GXU, OP_GYU, OP_GXV, OP_GYV, OP_GXT, OP_GYT:
                begin
                    gs_reg[3'(rsp.op)] <= ACC_BITS'(
                        sat_to(64'(gs_reg[3'(rsp.op)]) + term, ACC_BITS));
                end
                OP_UMU:
                    as_reg[4] <= ACC_BITS'(sat_to(64'(as_reg[4]) + term, ACC_BITS));
                OP_VMU:
                    as_reg[5] <= ACC_BITS'(sat_to(64'(as_reg[5]) + term, ACC_BITS));
                default:
                begin
                end
            endcase
        end
    end

    // Cell gradients, averages and flux terms
    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= head;
        if (issue && (issue_op == OP_SXX))
        begin
            ex_acc_reg <= '0;
            ey_acc_reg <= '0;
        end
        if (state_reg == S_OUT)
        begin
            ex_out_reg <= ex_sat[31:0];
            ey_out_reg <= ey_sat[31:0];
        end
        if (rsp.valid)
        begin
            case (rsp.op)
                OP_UX:   ux_reg   <= wb_neg_sat[OPW-1:0];
                OP_UY:   uy_reg   <= wb_neg_sat[OPW-1:0];
                OP_VX:   vx_reg   <= wb_neg_sat[OPW-1:0];
                OP_VY:   vy_reg   <= wb_neg_sat[OPW-1:0];
                OP_TX:   tx_reg   <= wb_neg_sat[OPW-1:0];
                OP_TY:   ty_reg   <= wb_neg_sat[OPW-1:0];
                OP_MUA:  mua_reg  <= wb_sat[OPW-1:0];
                OP_KPA:  kpa_reg  <= wb_sat[OPW-1:0];
                OP_UMUA: umua_reg <= wb_sat[OPW-1:0];
                OP_VMUA: vmua_reg <= wb_sat[OPW-1:0];
                OP_DD:   dd_reg   <= wb_sat[OPW-1:0];
                OP_SXX:  sxx_reg  <= wb_dbl_sat[31:0];
                OP_SXY:  sxy_reg  <= wb_sat[31:0];
                OP_SYY:  syy_reg  <= wb_dbl_sat[31:0];
                OP_EXA:  ex_acc_reg <= ex_acc_reg + (term <<< 1);
                OP_EXB, OP_EXC:
                         ex_acc_reg <= ex_acc_reg + term;
                OP_EYA:  ey_acc_reg <= ey_acc_reg + (term <<< 1);
                OP_EYB, OP_EYC:
                         ey_acc_reg <= ey_acc_reg + term;
                default:
                begin
                end
            endcase
        end
    end

    assign done      = done_reg;
    assign stress_xx = sxx_reg;
    assign stress_xy = sxy_reg;
    assign energy_x  = ex_out_reg;
    assign stress_yy = syy_reg;
    assign energy_y  = ey_out_reg;

    // A result only follows the output state
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_OUT))
        else $error("result strobe outside output state");

    // Dependent phases start only on a drained multiplier
    a_barrier: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && barrier) |-> !pending)
        else $error("phase started with products in flight");

    // No load while products are outstanding
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !pending && !rsp.valid)
        else $error("new corner loaded during writeback");

endmodule

@@ sv/triangle_viscous_flux.sv @@
// Viscous flux of one linear triangular cell, taken as three corner commands.
// Corners 0 and 1 run only the gradient and velocity-viscosity products; corner 2
// runs every product and then gives its result. All products share one
// pipelined multiplier, and two commands can queue ahead of the one in work.
// Reset (rst_n, async, active low) clears the queue, sequencer and cell sums.
// Results appear for one cycle on done; the receiver cannot stall.
`timescale 1ns / 1ps

module triangle_viscous_flux
    import tvf_pkg::*;
#(
    parameter int FRAC_BITS = 20,
    parameter int WORD_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         corner,
    input  logic signed [31:0] vel_u,
    input  logic signed [31:0] vel_v,
    input  logic signed [31:0] temperature,
    input  logic        [30:0] viscosity,
    input  logic        [30:0] conductivity,
    input  logic signed [31:0] grad_x,
    input  logic signed [31:0] grad_y,
    input  logic signed [31:0] cell_scale,
    output logic               done,
    output logic signed [31:0] stress_xx,
    output logic signed [31:0] stress_xy,
    output logic signed [31:0] energy_x,
    output logic signed [31:0] stress_yy,
    output logic signed [31:0] energy_y
);

    item_t                 head;
    logic                  head_valid;
    logic                  pop;
    mul_req_t              req;
    mul_rsp_t              rsp;
    logic signed [OPW-1:0] op_a, op_b;
    logic                  pending;

    tvf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .corner       (corner),
        .vel_u        (vel_u),
        .vel_v        (vel_v),
        .temperature  (temperature),
        .viscosity    (viscosity),
        .conductivity (conductivity),
        .grad_x       (grad_x),
        .grad_y       (grad_y),
        .cell_scale   (cell_scale),
        .pop          (pop),
        .head_valid   (head_valid),
        .head         (head)
    );

    tvf_back #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .req        (req),
        .op_a       (op_a),
        .op_b       (op_b),
        .rsp        (rsp),
        .pending    (pending),
        .done       (done),
        .stress_xx  (stress_xx),
        .stress_xy  (stress_xy),
        .energy_x   (energy_x),
        .stress_yy  (stress_yy),
        .energy_y   (energy_y)
    );

    tvf_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .op_a    (op_a),
        .op_b    (op_b),
        .rsp     (rsp),
        .pending (pending)
    );

endmodule
